@@ rtl/tss_pkg.sv @@
package tss_pkg;

    // Main sequence states, encoded as the main_state output field.
    typedef enum logic [2:0] {
        ST_START     = 3'd0,
        ST_DISCHARGE = 3'd1,
        ST_PRECHARGE = 3'd2,
        ST_TS_ACTIVE = 3'd3,
        ST_READY     = 3'd4
    } t_seq_state;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BUTTON_HOLD   = 3'd0,
        REG_DRIVE_RELEASE = 3'd1,
        REG_DISCHARGE     = 3'd2,
        REG_PRECHARGE     = 3'd3,
        REG_INV_TIMEOUT   = 3'd4
    } t_reg_index;

    localparam int TICK_W    = 24;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [TICK_W-1:0]    BUTTON_HOLD_RST   = 24'd200000;
    localparam logic [TICK_W-1:0]    DRIVE_RELEASE_RST = 24'd20000;
    localparam logic [TICK_W-1:0]    DISCHARGE_RST     = 24'd500000;
    localparam logic [TICK_W-1:0]    PRECHARGE_RST     = 24'd1000000;
    localparam logic [TIMEOUT_W-1:0] INV_TIMEOUT_RST   = 16'd150;

    // One captured tick.
    typedef struct packed {
        logic                 start_button;
        logic                 ready_button;
        logic                 brake_applied;
        logic                 bus_voltage_ok;
        logic                 link_lost;
        logic [TIMEOUT_W-1:0] inverter_wait;
        logic                 inverter_ok;
        logic                 insulation_ok;
        logic                 brake_plaus_ok;
    } t_tss_in;

    // Timing configuration as seen by the sequencing logic.
    typedef struct packed {
        logic [TICK_W-1:0]    button_hold_ticks;
        logic [TICK_W-1:0]    drive_release_ticks;
        logic [TICK_W-1:0]    discharge_ticks;
        logic [TICK_W-1:0]    precharge_ticks;
        logic [TIMEOUT_W-1:0] inverter_timeout;
    } t_tss_cfg;

    // One-tick message and buzzer requests.
    typedef struct packed {
        logic torque_enable;
        logic torque_disable;
        logic buzzer;
    } t_tss_pulses;

endpackage

@@ rtl/tss_step.sv @@
module tss_step #(
    parameter int COUNT_WIDTH = 24
) (
    input  tss_pkg::t_tss_in         i_in,
    input  tss_pkg::t_tss_cfg        i_cfg,
    input  tss_pkg::t_seq_state      i_state,
    input  logic                     i_err,
    input  logic [COUNT_WIDTH-1:0]   i_start_cnt,
    input  logic [COUNT_WIDTH-1:0]   i_ready_cnt,
    input  logic [COUNT_WIDTH-1:0]   i_release_cnt,
    input  logic [COUNT_WIDTH-1:0]   i_precharge_cnt,
    input  logic [COUNT_WIDTH-1:0]   i_discharge_cnt,
    input  logic                     i_relay,
    input  logic                     i_shutdown,
    output tss_pkg::t_seq_state      o_state,
    output logic                     o_err,
    output logic [COUNT_WIDTH-1:0]   o_start_cnt,
    output logic [COUNT_WIDTH-1:0]   o_ready_cnt,
    output logic [COUNT_WIDTH-1:0]   o_release_cnt,
    output logic [COUNT_WIDTH-1:0]   o_precharge_cnt,
    output logic [COUNT_WIDTH-1:0]   o_discharge_cnt,
    output logic                     o_relay,
    output logic                     o_shutdown,
    output tss_pkg::t_tss_pulses     o_pulses
);
    import tss_pkg::*;

    // Compare width covers both the counters and the tick registers.
    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;

    logic [COUNT_WIDTH-1:0] start_inc;
    logic [COUNT_WIDTH-1:0] ready_inc;
    logic [COUNT_WIDTH-1:0] release_inc;
    logic [COUNT_WIDTH-1:0] precharge_inc;
    logic [COUNT_WIDTH-1:0] discharge_inc;
    logic                   start_done;
    logic                   ready_done;
    logic                   release_done;
    logic                   precharge_done;
    logic                   discharge_done;
    logic                   fault;

    // Saturating increments.
    assign start_inc     = (&i_start_cnt)     ? i_start_cnt     : i_start_cnt + 1'b1;
    assign ready_inc     = (&i_ready_cnt)     ? i_ready_cnt     : i_ready_cnt + 1'b1;
    assign release_inc   = (&i_release_cnt)   ? i_release_cnt   : i_release_cnt + 1'b1;
    assign precharge_inc = (&i_precharge_cnt) ? i_precharge_cnt : i_precharge_cnt + 1'b1;
    assign discharge_inc = (&i_discharge_cnt) ? i_discharge_cnt : i_discharge_cnt + 1'b1;

    assign start_done = CMP_W'(start_inc) > CMP_W'(i_cfg.button_hold_ticks);
    assign ready_done = CMP_W'(ready_inc) > CMP_W'(i_cfg.button_hold_ticks);
    assign release_done = CMP_W'(release_inc) > CMP_W'(i_cfg.drive_release_ticks);
    assign precharge_done = CMP_W'(precharge_inc) > CMP_W'(i_cfg.precharge_ticks);
    assign discharge_done = CMP_W'(discharge_inc) > CMP_W'(i_cfg.discharge_ticks);

    assign fault = i_in.link_lost || (i_in.inverter_wait > i_cfg.inverter_timeout) ||
                   !i_in.inverter_ok || !i_in.insulation_ok || !i_in.brake_plaus_ok;

    always_comb begin
        o_state         = i_state;
        o_err           = i_err;
        o_start_cnt     = i_start_cnt;
        o_ready_cnt     = i_ready_cnt;
        o_release_cnt   = i_release_cnt;
        o_precharge_cnt = i_precharge_cnt;
        o_discharge_cnt = i_discharge_cnt;
        o_relay         = i_relay;
        o_shutdown      = i_shutdown;
        o_pulses        = '0;

        if (!i_err) begin
            if (fault) begin
                o_err      = 1'b1;
                o_shutdown = 1'b1;
            end else begin
                unique case (i_state)
                    ST_START: begin
                        if (i_in.start_button) begin
                            o_start_cnt = start_inc;
                            if (start_done) begin
                                o_start_cnt = '0;
                                o_state     = ST_PRECHARGE;
                            end
                        end else begin
                            o_start_cnt = '0;
                        end
                    end
                    ST_DISCHARGE: begin
                        o_relay         = 1'b1;
                        o_shutdown      = 1'b1;
                        o_discharge_cnt = discharge_inc;
                        if (discharge_done) begin
                            o_discharge_cnt = '0;
                            o_state         = ST_START;
                        end
                    end
                    ST_PRECHARGE: begin
                        o_relay         = 1'b0;
                        o_precharge_cnt = precharge_inc;
                        if (i_in.start_button) begin
                            o_start_cnt     = start_inc;
                            o_precharge_cnt = '0;
                            if (start_done) begin
                                o_start_cnt = '0;
                                o_state     = ST_DISCHARGE;
                            end
                        end else if (precharge_done && i_in.bus_voltage_ok) begin
                            o_shutdown      = 1'b0;
                            o_relay         = 1'b1;
                            o_start_cnt     = '0;
                            o_precharge_cnt = '0;
                            o_state         = ST_TS_ACTIVE;
                        end else begin
                            o_start_cnt = '0;
                        end
                    end
                    ST_TS_ACTIVE: begin
                        // The start button takes priority over the ready button.
                        if (i_in.start_button) begin
                            o_start_cnt = start_inc;
                            if (start_done) begin
                                o_start_cnt = '0;
                                o_state     = ST_DISCHARGE;
                            end
                        end else if (i_in.ready_button) begin
                            o_ready_cnt = ready_inc;
                            if (ready_done && i_in.brake_applied) begin
                                o_ready_cnt             = '0;
                                o_state                 = ST_READY;
                                o_pulses.torque_enable  = 1'b1;
                                o_pulses.buzzer         = 1'b1;
                            end
                        end
                    end
                    ST_READY: begin
                        if (i_in.ready_button) begin
                            o_release_cnt = release_inc;
                            if (release_done) begin
                                o_release_cnt           = '0;
                                o_state                 = ST_TS_ACTIVE;
                                o_pulses.torque_disable = 1'b1;
                            end
                        end else begin
                            o_release_cnt = '0;
                        end
                    end
                    default: begin
                        o_state = ST_START;
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/tractive_system_sequencer_core.sv @@
// Tractive system sequencer. Each input item is one control tick with the button
// levels and safety flags; each tick yields exactly one result item with the main
// state after the tick, the latched fatal error, the precharge relay and shutdown
// pin levels, and one-tick torque enable, torque disable and buzzer requests.
// A fatal error (link lost, inverter start wait above its timeout, or a low
// inverter, insulation or brake plausibility flag) latches until reset, opens the
// shutdown line and freezes the sequence. The block takes one item every clock
// cycle while the result side keeps up. An accepted item is captured in the input
// register and passes through the sequencing logic into the result register at the
// first clock edge when that register is empty or being drained; the sequencer
// state is updated at that same edge. A stalled result holds the input register,
// and the input stalls only once both registers are full.
// Configuration registers should be written only while no item is in flight.
// Hold and timer counters are COUNT_WIDTH bits wide and saturate at full scale.
module tractive_system_sequencer_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Tick channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_start_button,
    input  logic                            i_ready_button,
    input  logic                            i_brake_applied,
    input  logic                            i_bus_voltage_ok,
    input  logic                            i_link_lost,
    input  logic [tss_pkg::TIMEOUT_W-1:0]   i_inverter_wait,
    input  logic                            i_inverter_ok,
    input  logic                            i_insulation_ok,
    input  logic                            i_brake_plaus_ok,
    // Result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_main_state,
    output logic                            o_fault_latched,
    output logic                            o_precharge_relay_off,
    output logic                            o_shutdown_pin,
    output logic                            o_torque_enable_pulse,
    output logic                            o_torque_disable_pulse,
    output logic                            o_buzzer_pulse,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tss_pkg::TICK_W-1:0]      i_cfg_data
);
    import tss_pkg::*;

    // Pipeline control: the input register advances whenever the result
    // register is empty or being drained, so items flow one per cycle while not stalled.
    logic     r_in_valid;
    t_tss_in  r_in;
    logic     r_out_valid;
    logic     out_ready;
    logic     in_ready;
    logic     advance;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = !in_ready;
    assign o_valid   = r_out_valid;

    // Configuration registers.
    t_tss_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_hold_ticks   <= BUTTON_HOLD_RST;
            r_cfg.drive_release_ticks <= DRIVE_RELEASE_RST;
            r_cfg.discharge_ticks     <= DISCHARGE_RST;
            r_cfg.precharge_ticks     <= PRECHARGE_RST;
            r_cfg.inverter_timeout    <= INV_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BUTTON_HOLD:   r_cfg.button_hold_ticks   <= i_cfg_data;
                REG_DRIVE_RELEASE: r_cfg.drive_release_ticks <= i_cfg_data;
                REG_DISCHARGE:     r_cfg.discharge_ticks     <= i_cfg_data;
                REG_PRECHARGE:     r_cfg.precharge_ticks     <= i_cfg_data;
                REG_INV_TIMEOUT:   r_cfg.inverter_timeout    <= i_cfg_data[TIMEOUT_W-1:0];
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in.start_button   <= i_start_button;
            r_in.ready_button   <= i_ready_button;
            r_in.brake_applied  <= i_brake_applied;
            r_in.bus_voltage_ok <= i_bus_voltage_ok;
            r_in.link_lost      <= i_link_lost;
            r_in.inverter_wait  <= i_inverter_wait;
            r_in.inverter_ok    <= i_inverter_ok;
            r_in.insulation_ok  <= i_insulation_ok;
            r_in.brake_plaus_ok <= i_brake_plaus_ok;
        end
    end

    // Sequencer state.
    t_seq_state             r_state;
    logic                   r_err;
    logic [COUNT_WIDTH-1:0] r_start_cnt;
    logic [COUNT_WIDTH-1:0] r_ready_cnt;
    logic [COUNT_WIDTH-1:0] r_release_cnt;
    logic [COUNT_WIDTH-1:0] r_precharge_cnt;
    logic [COUNT_WIDTH-1:0] r_discharge_cnt;
    logic                   r_relay;
    logic                   r_shutdown;

    t_seq_state             n_state;
    logic                   n_err;
    logic [COUNT_WIDTH-1:0] n_start_cnt;
    logic [COUNT_WIDTH-1:0] n_ready_cnt;
    logic [COUNT_WIDTH-1:0] n_release_cnt;
    logic [COUNT_WIDTH-1:0] n_precharge_cnt;
    logic [COUNT_WIDTH-1:0] n_discharge_cnt;
    logic                   n_relay;
    logic                   n_shutdown;
    t_tss_pulses            n_pulses;

    tss_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_in            (r_in),
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_err           (r_err),
        .i_start_cnt     (r_start_cnt),
        .i_ready_cnt     (r_ready_cnt),
        .i_release_cnt   (r_release_cnt),
        .i_precharge_cnt (r_precharge_cnt),
        .i_discharge_cnt (r_discharge_cnt),
        .i_relay         (r_relay),
        .i_shutdown      (r_shutdown),
        .o_state         (n_state),
        .o_err           (n_err),
        .o_start_cnt     (n_start_cnt),
        .o_ready_cnt     (n_ready_cnt),
        .o_release_cnt   (n_release_cnt),
        .o_precharge_cnt (n_precharge_cnt),
        .o_discharge_cnt (n_discharge_cnt),
        .o_relay         (n_relay),
        .o_shutdown      (n_shutdown),
        .o_pulses        (n_pulses)
    );

    // The relay and shutdown levels come up at their safe, open level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_START;
            r_err           <= 1'b0;
            r_start_cnt     <= '0;
            r_ready_cnt     <= '0;
            r_release_cnt   <= '0;
            r_precharge_cnt <= '0;
            r_discharge_cnt <= '0;
            r_relay         <= 1'b1;
            r_shutdown      <= 1'b1;
        end else if (advance) begin
            r_state         <= n_state;
            r_err           <= n_err;
            r_start_cnt     <= n_start_cnt;
            r_ready_cnt     <= n_ready_cnt;
            r_release_cnt   <= n_release_cnt;
            r_precharge_cnt <= n_precharge_cnt;
            r_discharge_cnt <= n_discharge_cnt;
            r_relay         <= n_relay;
            r_shutdown      <= n_shutdown;
        end
    end

    // Result register.
    logic [2:0]  r_out_state;
    logic        r_out_err;
    logic        r_out_relay;
    logic        r_out_shutdown;
    t_tss_pulses r_out_pulses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state    <= n_state;
            r_out_err      <= n_err;
            r_out_relay    <= n_relay;
            r_out_shutdown <= n_shutdown;
            r_out_pulses   <= n_pulses;
        end
    end

    assign o_main_state           = r_out_state;
    assign o_fault_latched        = r_out_err;
    assign o_precharge_relay_off  = r_out_relay;
    assign o_shutdown_pin         = r_out_shutdown;
    assign o_torque_enable_pulse  = r_out_pulses.torque_enable;
    assign o_torque_disable_pulse = r_out_pulses.torque_disable;
    assign o_buzzer_pulse         = r_out_pulses.buzzer;

`ifndef NO_ASSERTIONS
    // A latched fatal error stays latched until reset.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("fatal error latch cleared without reset");

    // A held item in the input register stays there while the result side is blocked.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> r_in_valid)
        else $error("input register dropped a blocked item");

    // Entering ready to drive is the only way to raise torque enable and buzzer.
    a_enable_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_pulses.torque_enable || r_out_pulses.buzzer)) |->
        (r_out_state == 3'(ST_READY)))
        else $error("torque enable or buzzer outside ready to drive");

    // Leaving ready to drive always returns to tractive active.
    a_disable_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pulses.torque_disable) |->
        (r_out_state == 3'(ST_TS_ACTIVE)))
        else $error("torque disable pulse without return to tractive active");

    // With a fatal error reported the shutdown line is always open.
    a_err_shutdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> r_out_shutdown)
        else $error("shutdown line closed while fatal error latched");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the tractive system sequencer core.
//
// Every accepted input item is one control tick. The driver below predicts the
// result of each tick with its own copy of the sequencer state and timing
// registers, and the monitor checks each result item, in order, against the
// oldest prediction. The block produces exactly one result per tick, so once
// every prediction has been matched the block is idle and timing registers may
// be rewritten.
//
// The run goes through a short directed walk of the whole sequence, then a
// series of timing settings (all zero, ticks one below full scale, and random small
// values) fed with button gestures that look like real use: held start and
// ready buttons, precharge waits with the bus voltage flag toggling, and some
// noise. The fatal error latches until reset, and reset is applied only once,
// so the error check is exercised last.
module tb_top;
    import tss_pkg::*;

    localparam int                CNT_W        = 24;
    localparam logic [TICK_W-1:0] MAX_TICKS    = 24'd16777214;
    // Index past the last register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;
    localparam int                LONG_HOLD    = 80;
    localparam int                MAX_REPORTS  = 10;

    // Expected content of one result item.
    typedef struct packed {
        t_seq_state  main_state;
        logic        fault_latched;
        logic        relay_off;
        logic        shutdown;
        t_tss_pulses pulses;
    } t_tick_result;

    logic i_clk;
    logic rst_n = 1'b0;

    // Tick channel, driven by the driver process.
    logic    tick_valid = 1'b0;
    t_tss_in tick_drv   = '0;
    logic    tick_stall;

    // Result channel.
    logic       res_valid;
    logic       res_stall = 1'b1;
    logic [2:0] res_state;
    logic       res_fatal;
    logic       res_relay_off;
    logic       res_shutdown;
    logic       res_torque_en;
    logic       res_torque_dis;
    logic       res_buzzer;

    // Configuration port, driven by the main sequence only.
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_data  = '0;

    tractive_system_sequencer_core #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (rst_n),
        .i_valid               (tick_valid),
        .o_stall               (tick_stall),
        .i_start_button        (tick_drv.start_button),
        .i_ready_button        (tick_drv.ready_button),
        .i_brake_applied       (tick_drv.brake_applied),
        .i_bus_voltage_ok      (tick_drv.bus_voltage_ok),
        .i_link_lost           (tick_drv.link_lost),
        .i_inverter_wait       (tick_drv.inverter_wait),
        .i_inverter_ok         (tick_drv.inverter_ok),
        .i_insulation_ok       (tick_drv.insulation_ok),
        .i_brake_plaus_ok      (tick_drv.brake_plaus_ok),
        .o_valid               (res_valid),
        .i_stall               (res_stall),
        .o_main_state          (res_state),
        .o_fault_latched       (res_fatal),
        .o_precharge_relay_off (res_relay_off),
        .o_shutdown_pin        (res_shutdown),
        .o_torque_enable_pulse (res_torque_en),
        .o_torque_disable_pulse(res_torque_dis),
        .o_buzzer_pulse        (res_buzzer),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Predictor state: a private copy of the sequencer and its timing registers.
    t_tss_cfg         seq_cfg = '{BUTTON_HOLD_RST, DRIVE_RELEASE_RST, DISCHARGE_RST,
                                  PRECHARGE_RST, INV_TIMEOUT_RST};
    t_seq_state       seq_st       = ST_START;
    logic             err_latched  = 1'b0;
    logic [CNT_W-1:0] start_cnt    = '0;
    logic [CNT_W-1:0] ready_cnt    = '0;
    logic [CNT_W-1:0] release_cnt  = '0;
    logic [CNT_W-1:0] precharge_cnt = '0;
    logic [CNT_W-1:0] discharge_cnt = '0;
    logic             relay_lvl    = 1'b1;
    logic             shutdown_lvl = 1'b1;

    t_tss_in      pending_ticks[$];
    t_tick_result expected_outputs[$];
    t_tick_result pred_staged;
    logic         pred_ready = 1'b0;

    int ticks_accepted  = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int settings_used   = 0;
    int drive_entries   = 0;
    int drive_exits     = 0;
    int frozen_ticks    = 0;
    int long_hold_reqs  = 0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advances the predicted sequencer by one tick and returns the result item
    // that the block must produce for it.
    function automatic t_tick_result sequencer_step(input t_tss_in t);
        t_tick_result r;
        r.pulses = '0;
        if (err_latched) begin
            frozen_ticks++;
        end else if (t.link_lost || t.inverter_wait > seq_cfg.inverter_timeout ||
                     !t.inverter_ok || !t.insulation_ok || !t.brake_plaus_ok) begin
            // The error tick opens the shutdown line and does not advance.
            err_latched  = 1'b1;
            shutdown_lvl = 1'b1;
        end else begin
            case (seq_st)
                ST_START: begin
                    if (t.start_button) begin
                        start_cnt = sat_inc(start_cnt);
                        if (start_cnt > seq_cfg.button_hold_ticks) begin
                            start_cnt = '0;
                            seq_st    = ST_PRECHARGE;
                        end
                    end else begin
                        start_cnt = '0;
                    end
                end
                ST_DISCHARGE: begin
                    relay_lvl     = 1'b1;
                    shutdown_lvl  = 1'b1;
                    discharge_cnt = sat_inc(discharge_cnt);
                    if (discharge_cnt > seq_cfg.discharge_ticks) begin
                        discharge_cnt = '0;
                        seq_st        = ST_START;
                    end
                end
                ST_PRECHARGE: begin
                    relay_lvl     = 1'b0;
                    precharge_cnt = sat_inc(precharge_cnt);
                    if (t.start_button) begin
                        // A held start button aborts precharge toward discharge.
                        start_cnt     = sat_inc(start_cnt);
                        precharge_cnt = '0;
                        if (start_cnt > seq_cfg.button_hold_ticks) begin
                            start_cnt = '0;
                            seq_st    = ST_DISCHARGE;
                        end
                    end else if (precharge_cnt > seq_cfg.precharge_ticks &&
                                 t.bus_voltage_ok) begin
                        shutdown_lvl  = 1'b0;
                        relay_lvl     = 1'b1;
                        start_cnt     = '0;
                        precharge_cnt = '0;
                        seq_st        = ST_TS_ACTIVE;
                    end else begin
                        start_cnt = '0;
                    end
                end
                ST_TS_ACTIVE: begin
                    // Start takes priority; the ready counter keeps its count
                    // until it causes the move to ready to drive.
                    if (t.start_button) begin
                        start_cnt = sat_inc(start_cnt);
                        if (start_cnt > seq_cfg.button_hold_ticks) begin
                            start_cnt = '0;
                            seq_st    = ST_DISCHARGE;
                        end
                    end else if (t.ready_button) begin
                        ready_cnt = sat_inc(ready_cnt);
                        if (ready_cnt > seq_cfg.button_hold_ticks && t.brake_applied) begin
                            ready_cnt              = '0;
                            seq_st                 = ST_READY;
                            r.pulses.torque_enable = 1'b1;
                            r.pulses.buzzer        = 1'b1;
                            drive_entries++;
                        end
                    end
                end
                ST_READY: begin
                    if (t.ready_button) begin
                        release_cnt = sat_inc(release_cnt);
                        if (release_cnt > seq_cfg.drive_release_ticks) begin
                            release_cnt             = '0;
                            seq_st                  = ST_TS_ACTIVE;
                            r.pulses.torque_disable = 1'b1;
                            drive_exits++;
                        end
                    end else begin
                        release_cnt = '0;
                    end
                end
                default: seq_st = ST_START;
            endcase
        end
        r.main_state    = seq_st;
        r.fault_latched = err_latched;
        r.relay_off     = relay_lvl;
        r.shutdown      = shutdown_lvl;
        return r;
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [TICK_W-1:0] data);
        case (idx)
            REG_BUTTON_HOLD:   seq_cfg.button_hold_ticks   = data;
            REG_DRIVE_RELEASE: seq_cfg.drive_release_ticks = data;
            REG_DISCHARGE:     seq_cfg.discharge_ticks     = data;
            REG_PRECHARGE:     seq_cfg.precharge_ticks     = data;
            REG_INV_TIMEOUT:   seq_cfg.inverter_timeout    = data[TIMEOUT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // A tick with every safety flag healthy and the inverter wait in range.
    function automatic t_tss_in safe_tick(input logic s, input logic r,
                                          input logic b, input logic v);
        t_tss_in t;
        t                = '0;
        t.start_button   = s;
        t.ready_button   = r;
        t.brake_applied  = b;
        t.bus_voltage_ok = v;
        t.inverter_ok    = 1'b1;
        t.insulation_ok  = 1'b1;
        t.brake_plaus_ok = 1'b1;
        t.inverter_wait  = 16'($urandom_range(0, int'(seq_cfg.inverter_timeout)));
        return t;
    endfunction

    function automatic int cap_len(input int unsigned x);
        return (x > 40) ? 40 : int'(x);
    endfunction

    // Queues one operator gesture sized around the current timing settings so
    // that holds land on both sides of their thresholds. Returns its length.
    function automatic int push_gesture();
        int n;
        int unsigned span;
        n = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, cap_len(seq_cfg.button_hold_ticks) + 2);
                repeat (n)
                    pending_ticks.push_back(safe_tick(1'b1, $urandom_range(0, 3) == 0,
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'($urandom_range(0, 1)),
                    1'b1));
                n++;
            end
            3, 4, 5: begin
                span = (seq_cfg.button_hold_ticks > seq_cfg.drive_release_ticks) ?
                       seq_cfg.button_hold_ticks : seq_cfg.drive_release_ticks;
                n = $urandom_range(1, cap_len(span) + 2);
                repeat (n)
                    pending_ticks.push_back(safe_tick(1'b0, 1'b1,
                        $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1))));
            end
            6, 7: begin
                span = (seq_cfg.precharge_ticks > seq_cfg.discharge_ticks) ?
                       seq_cfg.precharge_ticks : seq_cfg.discharge_ticks;
                n = $urandom_range(1, cap_len(span) + 3);
                repeat (n)
                    pending_ticks.push_back(safe_tick(1'b0, $urandom_range(0, 7) == 0,
                        1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0));
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n)
                    pending_ticks.push_back(safe_tick(1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1))));
            end
        endcase
        return n;
    endfunction

    // Driver: offers queued ticks in bursts of random length separated by random
    // gaps. A payload is held unchanged while the block stalls. The prediction
    // for an accepted tick is staged here and queued by the monitor in the following
    // cycle, so the two processes never touch the queue in the same way at once.
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            tick_valid <= 1'b0;
            pred_ready <= 1'b0;
        end else begin
            pred_ready <= tick_valid && !tick_stall;
            if (tick_valid && !tick_stall) begin
                pred_staged <= sequencer_step(tick_drv);
                ticks_accepted++;
            end
            if (!tick_valid || !tick_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    tick_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    tick_drv   <= pending_ticks.pop_front();
                    tick_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: a pattern that changes mode at random intervals (never,
    // sparse, heavy, periodic), plus a long hold-off whenever one is requested.
    int       hold_cnt   = 0;
    int       holds_done = 0;
    int       mode_cnt   = 0;
    bit [1:0] stall_mode = 2'd0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            res_stall <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt  <= hold_cnt - 1;
            res_stall <= 1'b1;
        end else if (holds_done != long_hold_reqs) begin
            holds_done <= holds_done + 1;
            hold_cnt   <= LONG_HOLD;
            res_stall  <= 1'b1;
        end else begin
            if (mode_cnt == 0) begin
                stall_mode <= 2'($urandom_range(0, 3));
                mode_cnt   <= $urandom_range(16, 96);
            end else begin
                mode_cnt <= mode_cnt - 1;
            end
            case (stall_mode)
                2'd0: res_stall <= 1'b0;
                2'd1: res_stall <= ($urandom_range(0, 3) == 0);
                2'd2: res_stall <= ($urandom_range(0, 4) < 3);
                default: res_stall <= (mode_cnt[1:0] == 2'd0);
            endcase
        end
    end

    // Monitor: every accepted result item is compared with the oldest
    // prediction. The prediction staged by the driver is queued after the
    // compare, which is safe because a result must pass the input and result registers.
    t_tick_result want;

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                if (expected_outputs.size() == 0) begin
                    note_failure($sformatf("unexpected result: state=%0d err=%b", res_state,
                                           res_fatal));
                end else begin
                    want = expected_outputs.pop_front();
                    if (res_state !== want.main_state || res_fatal !== want.fault_latched ||
                        res_relay_off !== want.relay_off || res_shutdown !== want.shutdown ||
                        res_torque_en !== want.pulses.torque_enable ||
                        res_torque_dis !== want.pulses.torque_disable ||
                        res_buzzer !== want.pulses.buzzer)
                        note_failure($sformatf({"result %0d mismatch: expected state=%0d ",
                            "err=%b relay=%b sd=%b en=%b dis=%b buzz=%b, got state=%0d ",
                            "err=%b relay=%b sd=%b en=%b dis=%b buzz=%b"}, results_checked,
                            want.main_state, want.fault_latched, want.relay_off,
                            want.shutdown, want.pulses.torque_enable,
                            want.pulses.torque_disable, want.pulses.buzzer, res_state,
                            res_fatal, res_relay_off, res_shutdown, res_torque_en,
                            res_torque_dis, res_buzzer));
                    results_checked++;
                end
            end
            if (pred_ready)
                expected_outputs.push_back(pred_staged);
        end
    end

    // Waits until no tick is queued, offered or in flight.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || tick_valid || pred_ready ||
               expected_outputs.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_cfg(idx, data);
    endtask

    // Writes all timing registers. The timeout goes out with junk in the upper
    // byte, which the block must drop, and one write lands on an unmapped index.
    task automatic set_timing(input logic [TICK_W-1:0] hold, input logic [TICK_W-1:0] rel,
                              input logic [TICK_W-1:0] dis, input logic [TICK_W-1:0] pre,
                              input logic [TIMEOUT_W-1:0] tmo);
        write_reg(REG_BUTTON_HOLD, hold);
        write_reg(REG_DRIVE_RELEASE, rel);
        write_reg(REG_DISCHARGE, dis);
        write_reg(REG_PRECHARGE, pre);
        write_reg(REG_INV_TIMEOUT, {8'($urandom), tmo});
        write_reg(UNMAPPED_REG, 24'($urandom));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        case ($urandom_range(0, 2))
            0:       return '1;
            1:       return 16'($urandom_range(0, 300));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Main sequence: reset, directed walk, a series of timing settings, error last.
    initial begin
        t_tss_in t;
        int      queued;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset timing: a short start press goes nowhere, and a wait equal to
        // the default timeout is still healthy.
        pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'b0, 1'b0));
        t = safe_tick(1'b1, 1'b0, 1'b0, 1'b1);
        t.inverter_wait = INV_TIMEOUT_RST;
        pending_ticks.push_back(t);
        pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'b0, 1'b1));
        wait_drained();

        // Directed walk with hold registers set to one tick and a short precharge.
        set_timing(24'd1, 24'd1, 24'd1, 24'd2, 16'd150);
        repeat (2) pending_ticks.push_back(safe_tick(1'b1, 1'b0, 1'b0, 1'b0));
        // Precharge runs past its minimum but waits for the bus voltage.
        repeat (3) pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'b0, 1'b0));
        pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'b0, 1'b1));
        // Ready held without brakes keeps counting, then brakes complete it.
        repeat (2) pending_ticks.push_back(safe_tick(1'b0, 1'b1, 1'b0, 1'b1));
        pending_ticks.push_back(safe_tick(1'b0, 1'b1, 1'b1, 1'b1));
        // In ready to drive the start button means nothing; ready held leaves.
        pending_ticks.push_back(safe_tick(1'b1, 1'b0, 1'b1, 1'b1));
        repeat (2) pending_ticks.push_back(safe_tick(1'b0, 1'b1, 1'b0, 1'b1));
        // Both buttons in tractive active: start wins and leads to discharge.
        repeat (2) pending_ticks.push_back(safe_tick(1'b1, 1'b1, 1'b1, 1'b1));
        repeat (2) pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'b0, 1'b1));
        // Start, then abort precharge with a second long press.
        repeat (4) pending_ticks.push_back(safe_tick(1'b1, 1'b0, 1'b0, 1'b0));
        repeat (2) pending_ticks.push_back(safe_tick(1'b0, 1'b0, 1'b0, 1'b0));
        t = safe_tick(1'b0, 1'b0, 1'b0, 1'b1);
        t.inverter_wait = 16'd150;
        pending_ticks.push_back(t);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            case (p)
                0:       set_timing('0, '0, '0, '0, '0);
                1:       set_timing(MAX_TICKS, MAX_TICKS, MAX_TICKS, MAX_TICKS, '1);
                default: set_timing(24'($urandom_range(0, 5)), 24'($urandom_range(0, 5)),
                                    24'($urandom_range(0, 8)), 24'($urandom_range(0, 8)),
                                    pick_timeout());
            endcase
            queued = 0;
            if (p == 1) begin
                t = safe_tick(1'b1, 1'b1, 1'b1, 1'b1);
                t.inverter_wait = '1;
                pending_ticks.push_back(t);
            end
            // In one setting the receiver holds off long enough to back the
            // block up into its input while ticks keep coming.
            if (p == 3)
                long_hold_reqs++;
            while (queued < ((p == 1) ? 80 : 160))
                queued += push_gesture();
        end

        // Fatal error last: a wait one above the timeout latches it, then each
        // other cause and random noise must leave the sequence frozen.
        wait_drained();
        set_timing(24'd1, 24'd1, 24'd2, 24'd3, 16'd100);
        repeat (6) void'(push_gesture());
        t = safe_tick(1'b0, 1'b0, 1'b0, 1'b1);
        t.inverter_wait = 16'd101;
        pending_ticks.push_back(t);
        t = safe_tick(1'b1, 1'b1, 1'b1, 1'b1);
        t.link_lost = 1'b1;
        pending_ticks.push_back(t);
        t = safe_tick(1'b1, 1'b0, 1'b1, 1'b1);
        t.inverter_ok = 1'b0;
        pending_ticks.push_back(t);
        t = safe_tick(1'b0, 1'b1, 1'b1, 1'b0);
        t.insulation_ok = 1'b0;
        pending_ticks.push_back(t);
        t = safe_tick(1'b0, 1'b1, 1'b0, 1'b1);
        t.brake_plaus_ok = 1'b0;
        pending_ticks.push_back(t);
        repeat (40) pending_ticks.push_back(t_tss_in'(24'($urandom)));

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_outputs.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_outputs.size()));

        $display("Covered %0d ticks over %0d timing settings; %0d results checked.",
                 ticks_accepted, settings_used, results_checked);
        $display("Drive mode entered %0d times, left %0d times; %0d ticks after fatal latch.",
                 drive_entries, drive_exits, frozen_ticks);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard limit far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
